### hdl/tcpqs_pkg.sv
// shared types for the two-class priority queue server
`default_nettype none
package tcpqs_pkg;

   localparam int ID_W    = 16;
   localparam int TICK_W  = 32;
   localparam int SLEN_W  = 4;
   localparam int SUM_W   = 48;
   localparam int CNT_W   = 32;
   localparam int OCC_W   = 3;
   localparam int REQ_W   = 8;
   localparam int RSP_W   = 224;

   typedef struct packed {
      logic [SLEN_W-1:0] slen;
      logic [TICK_W-1:0] tick;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic      fire;
      logic      push;
      logic      pop;
      entry_type entry;
   } ring_ctrl_type;

   typedef struct packed {
      logic             empty;
      logic             full;
      logic [OCC_W-1:0] fill;
   } ring_stat_type;

endpackage
`default_nettype wire

### hdl/tcpqs_ring.sv
// circular fifo for one class with a prefetched head entry
`default_nettype none
module tcpqs_ring #(
   parameter int RING_SLOTS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire tcpqs_pkg::ring_ctrl_type ctrl,
   output tcpqs_pkg::ring_stat_type      stat,
   output tcpqs_pkg::entry_type          pop_entry
);
   import tcpqs_pkg::*;

   localparam int PW = $clog2(RING_SLOTS);
   localparam int FW = PW + 1;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] i);
      ring_next = (i == PW'(RING_SLOTS - 1)) ? '0 : i + PW'(1);
   endfunction

   entry_type     mem [RING_SLOTS];
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, rd_addr;
   entry_type     rdata_ff, byp_data_ff, front;
   logic          byp_ff;
   logic          ring_empty;
   logic [FW-1:0] fill;
   logic [FW+2:0] fill_ext;

   assign ring_empty = (head_ff == tail_ff);
   assign stat.empty = ring_empty;
   assign stat.full  = (ring_next(tail_ff) == head_ff);
   assign stat.fill  = fill_ext[OCC_W-1:0];

   assign tail_in = ctrl.push ? ring_next(tail_ff) : tail_ff;
   assign head_in = ctrl.pop  ? ring_next(head_ff) : head_ff;
   assign rd_addr = ring_next(head_in);

   // an empty ring hands the entry being pushed straight through
   assign front     = byp_ff ? byp_data_ff : rdata_ff;
   assign pop_entry = ring_empty ? ctrl.entry : front;

   always_comb begin
      if (tail_in >= head_in) begin
         fill = {1'b0, tail_in} - {1'b0, head_in};
      end else begin
         fill = {1'b0, tail_in} + FW'(RING_SLOTS) - {1'b0, head_in};
      end
      fill_ext = {3'b000, fill};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         byp_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         if (ctrl.fire) begin
            byp_ff <= ctrl.push && (rd_addr == tail_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_in] <= ctrl.entry;
      end
      if (ctrl.fire) begin
         rdata_ff    <= mem[rd_addr];
         byp_data_ff <= ctrl.entry;
      end
   end

`ifndef SYNTH
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> (!ring_empty || ctrl.push))
      else $error("pop from empty ring");
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> !stat.full)
      else $error("push into full ring");
   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.pop) |=> !ring_empty)
      else $error("ring empty after push");
`endif

endmodule
`default_nettype wire

### hdl/tcpqs_core.sv
// tick processing: push, strict-priority start, counters and result register
`default_nettype none
module tcpqs_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   input  wire logic [tcpqs_pkg::REQ_W-1:0] in_data,
   output logic                          in_take,
   output tcpqs_pkg::ring_ctrl_type      h_ctrl,
   output tcpqs_pkg::ring_ctrl_type      n_ctrl,
   input  wire tcpqs_pkg::ring_stat_type h_stat,
   input  wire tcpqs_pkg::ring_stat_type n_stat,
   input  wire tcpqs_pkg::entry_type     h_front,
   input  wire tcpqs_pkg::entry_type     n_front,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [tcpqs_pkg::RSP_W-1:0]   rsp_tdata
);
   import tcpqs_pkg::*;

   logic [SLEN_W-1:0] rem_ff, rem_in;
   logic [TICK_W-1:0] tick_ff;
   logic [ID_W-1:0]   id_ff;
   logic [SUM_W-1:0]  hsum_ff, hsum_in, nsum_ff, nsum_in;
   logic [CNT_W-1:0]  hcnt_ff, hcnt_in, ncnt_ff, ncnt_in;
   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              arrival, is_high, dropped, busy, start;
   logic              h_push, n_push, h_avail, n_avail;
   logic [SLEN_W-1:0] slen;
   entry_type         new_entry, st_entry;
   logic [TICK_W-1:0] st_wait;
   logic [ID_W-1:0]   o_id;
   logic [TICK_W-1:0] o_wait;

   assign arrival = in_data[0];
   assign is_high = in_data[1];
   assign slen    = in_data[5:2];

   assign in_take = in_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      new_entry.slen = slen;
      new_entry.tick = tick_ff;
      new_entry.id   = id_ff;

      h_push  = in_take && arrival && is_high && !h_stat.full;
      n_push  = in_take && arrival && !is_high && !n_stat.full;
      dropped = arrival && (is_high ? h_stat.full : n_stat.full);

      busy    = (rem_ff != '0);
      h_avail = !h_stat.empty || h_push;
      n_avail = !n_stat.empty || n_push;
      start   = !busy && (h_avail || n_avail);

      h_ctrl.fire  = in_take;
      h_ctrl.push  = h_push;
      h_ctrl.pop   = in_take && start && h_avail;
      h_ctrl.entry = new_entry;
      n_ctrl.fire  = in_take;
      n_ctrl.push  = n_push;
      n_ctrl.pop   = in_take && start && !h_avail && n_avail;
      n_ctrl.entry = new_entry;

      st_entry = h_avail ? h_front : n_front;
      st_wait  = tick_ff - st_entry.tick;

      if (busy) begin
         rem_in = rem_ff - SLEN_W'(1);
      end else if (start) begin
         rem_in = st_entry.slen;
      end else begin
         rem_in = rem_ff;
      end

      hsum_in = hsum_ff;
      nsum_in = nsum_ff;
      if (start && h_avail) begin
         hsum_in = hsum_ff + SUM_W'(st_wait);
      end else if (start) begin
         nsum_in = nsum_ff + SUM_W'(st_wait);
      end
      hcnt_in = hcnt_ff + CNT_W'(h_push);
      ncnt_in = ncnt_ff + CNT_W'(n_push);

      o_id   = start ? st_entry.id : '0;
      o_wait = start ? st_wait : '0;
      rsp_data_in = {6'b000000, n_stat.fill, h_stat.fill, ncnt_in, hcnt_in,
                     nsum_in, hsum_in, dropped, busy, o_wait, o_id,
                     start && h_avail, start};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         tick_ff      <= '0;
         id_ff        <= '0;
         hsum_ff      <= '0;
         nsum_ff      <= '0;
         hcnt_ff      <= '0;
         ncnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (in_take) begin
            rem_ff  <= rem_in;
            tick_ff <= tick_ff + TICK_W'(1);
            id_ff   <= id_ff + ID_W'(h_push || n_push);
            hsum_ff <= hsum_in;
            nsum_ff <= nsum_in;
            hcnt_ff <= hcnt_in;
            ncnt_ff <= ncnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_one_pop: assert property (@(posedge clock) disable iff (reset)
      !(h_ctrl.pop && n_ctrl.pop))
      else $error("both classes popped in one tick");
   a_start_xor_busy: assert property (@(posedge clock) disable iff (reset)
      in_take |=> !(rsp_data_ff[0] && rsp_data_ff[50]))
      else $error("start reported while busy");
   a_rem_down: assert property (@(posedge clock) disable iff (reset)
      (in_take && busy) |=> (rem_ff == $past(rem_ff) - SLEN_W'(1)))
      else $error("remaining service not decremented");
`endif

endmodule
`default_nettype wire

### hdl/two_class_priority_queue_server.sv
// top level of the two-class strict-priority queue server
//
//   channel  dir  ports                         transfer
//   req      in   req_tvalid/tready/tdata[7:0]  one tick, optional arrival
//   rsp      out  rsp_tvalid/tready/tdata[223:0] one report per tick
//
// one tick per cycle sustained while rsp is ready; a tick lands in the input
// register, then the ring push, priority start and counter update run
// combinationally into the result register, from which the report is valid on rsp.
// ring head entries are read ahead into a register from each ring memory.
// synchronous reset empties both rings and clears all counters; ring memory
// itself is not cleared. a stalled rsp side holds the result and the input
// register keeps one more tick.
`default_nettype none
module two_class_priority_queue_server #(
   parameter int RING_SLOTS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // arrival, arrival_high_class, service_length[3:0], zero pad
   input  wire logic [tcpqs_pkg::REQ_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // service_started, started_high_class, started_id[15:0], started_wait[31:0],
   // server_busy, arrival_dropped, high_wait_total[47:0], normal_wait_total[47:0],
   // high_arrivals[31:0], normal_arrivals[31:0], high_waiting[2:0],
   // normal_waiting[2:0], zero pad
   output logic [tcpqs_pkg::RSP_W-1:0]       rsp_tdata
);
   import tcpqs_pkg::*;

   logic             in_valid_ff;
   logic [REQ_W-1:0] in_data_ff;
   logic             in_take;
   ring_ctrl_type    h_ctrl, n_ctrl;
   ring_stat_type    h_stat, n_stat;
   entry_type        h_front, n_front;

   assign req_tready = !in_valid_ff || in_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   tcpqs_ring #(.RING_SLOTS(RING_SLOTS)) u_high_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (h_ctrl),
      .stat      (h_stat),
      .pop_entry (h_front)
   );

   tcpqs_ring #(.RING_SLOTS(RING_SLOTS)) u_normal_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (n_ctrl),
      .stat      (n_stat),
      .pop_entry (n_front)
   );

   tcpqs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_data    (in_data_ff),
      .in_take    (in_take),
      .h_ctrl     (h_ctrl),
      .n_ctrl     (n_ctrl),
      .h_stat     (h_stat),
      .n_stat     (n_stat),
      .h_front    (h_front),
      .n_front    (n_front),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

### verif/two_class_priority_queue_server_checker.sv
// scoreboard: predicts each tick report of the queue server and compares it with the rsp side
`timescale 1ns / 1ps
module two_class_priority_queue_server_checker #(
   parameter int RING_SLOTS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_tready,
   input  wire logic [tcpqs_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic [tcpqs_pkg::RSP_W-1:0]  rsp_tdata,
   output int                                mismatch_count,
   output int                                reports_pending,
   output int                                starts_seen,
   output int                                high_starts_seen,
   output int                                drops_seen
);
   import tcpqs_pkg::*;

   // rsp_tdata layout, lowest field last
   typedef struct packed {
      logic [5:0]        pad;
      logic [OCC_W-1:0]  normal_waiting;
      logic [OCC_W-1:0]  high_waiting;
      logic [CNT_W-1:0]  normal_arrivals;
      logic [CNT_W-1:0]  high_arrivals;
      logic [SUM_W-1:0]  normal_wait_total;
      logic [SUM_W-1:0]  high_wait_total;
      logic              arrival_dropped;
      logic              server_busy;
      logic [TICK_W-1:0] started_wait;
      logic [ID_W-1:0]   started_id;
      logic              started_high_class;
      logic              service_started;
   } tick_report_type;

   tick_report_type expected_reports[$];

   // shadow copy of the server
   entry_type         high_ring[RING_SLOTS];
   entry_type         normal_ring[RING_SLOTS];
   int                high_head, high_tail, normal_head, normal_tail;
   logic [SLEN_W-1:0] service_left;
   logic [TICK_W-1:0] tick_now;
   logic [ID_W-1:0]   id_next;
   logic [SUM_W-1:0]  high_sum, normal_sum;
   logic [CNT_W-1:0]  high_accepted, normal_accepted;

   function automatic int ring_step(input int idx);
      return (idx + 1) % RING_SLOTS;
   endfunction

   function automatic logic [OCC_W-1:0] ring_occupancy(input int head, input int tail);
      int occ;
      occ = (tail + RING_SLOTS - head) % RING_SLOTS;
      return occ[OCC_W-1:0];
   endfunction

   task automatic serve_tick(input logic [REQ_W-1:0] tick_bits);
      tick_report_type rep;
      entry_type       arriving, leaving;
      logic            arrival, to_high, take_high;
      arrival  = tick_bits[0];
      to_high  = tick_bits[1];
      rep      = '0;
      arriving = '{slen: tick_bits[5:2], tick: tick_now, id: id_next};
      if (arrival) begin
         if (to_high && ring_step(high_tail) == high_head) begin
            rep.arrival_dropped = 1'b1;
         end else if (!to_high && ring_step(normal_tail) == normal_head) begin
            rep.arrival_dropped = 1'b1;
         end else if (to_high) begin
            high_tail = ring_step(high_tail);
            high_ring[high_tail] = arriving;
            high_accepted++;
            id_next++;
         end else begin
            normal_tail = ring_step(normal_tail);
            normal_ring[normal_tail] = arriving;
            normal_accepted++;
            id_next++;
         end
      end
      if (service_left != 0) begin
         service_left--;
         rep.server_busy = 1'b1;
      end else if (high_head != high_tail || normal_head != normal_tail) begin
         take_high = (high_head != high_tail);
         if (take_high) begin
            high_head = ring_step(high_head);
            leaving = high_ring[high_head];
         end else begin
            normal_head = ring_step(normal_head);
            leaving = normal_ring[normal_head];
         end
         rep.service_started    = 1'b1;
         rep.started_high_class = take_high;
         rep.started_id         = leaving.id;
         rep.started_wait       = tick_now - leaving.tick;
         service_left           = leaving.slen;
         if (take_high) high_sum += SUM_W'(rep.started_wait);
         else normal_sum += SUM_W'(rep.started_wait);
      end
      tick_now++;
      rep.high_wait_total   = high_sum;
      rep.normal_wait_total = normal_sum;
      rep.high_arrivals     = high_accepted;
      rep.normal_arrivals   = normal_accepted;
      rep.high_waiting      = ring_occupancy(high_head, high_tail);
      rep.normal_waiting    = ring_occupancy(normal_head, normal_tail);
      expected_reports.push_back(rep);
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                                input logic [63:0] got_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what,
                  exp_val, got_val);
   endtask

   task automatic compare_report(input tick_report_type exp_r, input tick_report_type got);
      if (got.service_started !== exp_r.service_started)
         note_mismatch("service_started", exp_r.service_started, got.service_started);
      if (got.started_high_class !== exp_r.started_high_class)
         note_mismatch("started_high_class", exp_r.started_high_class,
                       got.started_high_class);
      if (got.started_id !== exp_r.started_id)
         note_mismatch("started_id", exp_r.started_id, got.started_id);
      if (got.started_wait !== exp_r.started_wait)
         note_mismatch("started_wait", exp_r.started_wait, got.started_wait);
      if (got.server_busy !== exp_r.server_busy)
         note_mismatch("server_busy", exp_r.server_busy, got.server_busy);
      if (got.arrival_dropped !== exp_r.arrival_dropped)
         note_mismatch("arrival_dropped", exp_r.arrival_dropped, got.arrival_dropped);
      if (got.high_wait_total !== exp_r.high_wait_total)
         note_mismatch("high_wait_total", exp_r.high_wait_total, got.high_wait_total);
      if (got.normal_wait_total !== exp_r.normal_wait_total)
         note_mismatch("normal_wait_total", exp_r.normal_wait_total,
                       got.normal_wait_total);
      if (got.high_arrivals !== exp_r.high_arrivals)
         note_mismatch("high_arrivals", exp_r.high_arrivals, got.high_arrivals);
      if (got.normal_arrivals !== exp_r.normal_arrivals)
         note_mismatch("normal_arrivals", exp_r.normal_arrivals, got.normal_arrivals);
      if (got.high_waiting !== exp_r.high_waiting)
         note_mismatch("high_waiting", exp_r.high_waiting, got.high_waiting);
      if (got.normal_waiting !== exp_r.normal_waiting)
         note_mismatch("normal_waiting", exp_r.normal_waiting, got.normal_waiting);
   endtask

   initial begin
      mismatch_count   = 0;
      reports_pending  = 0;
      starts_seen      = 0;
      high_starts_seen = 0;
      drops_seen       = 0;
   end

   always @(posedge clock) begin : watch
      tick_report_type got;
      if (reset) begin
         high_head       = 0;
         high_tail       = 0;
         normal_head     = 0;
         normal_tail     = 0;
         service_left    = '0;
         tick_now        = '0;
         id_next         = '0;
         high_sum        = '0;
         normal_sum      = '0;
         high_accepted   = '0;
         normal_accepted = '0;
         expected_reports.delete();
      end else begin
         if (req_tvalid && req_tready)
            serve_tick(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (got.service_started === 1'b1) starts_seen++;
            if (got.service_started === 1'b1 && got.started_high_class === 1'b1)
               high_starts_seen++;
            if (got.arrival_dropped === 1'b1) drops_seen++;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t report with no tick outstanding: %0h", $realtime,
                           rsp_tdata);
            end else begin
               compare_report(expected_reports.pop_front(), got);
            end
         end
      end
      reports_pending = expected_reports.size();
   end

endmodule

### verif/two_class_priority_queue_server_tb.sv
// top of the queue server testbench: clock, reset, tick stimulus and the verdict
`timescale 1ns / 1ps
module two_class_priority_queue_server_tb;
   import tcpqs_pkg::*;

   localparam int TICK_TARGET = 1450;
   localparam int CYCLE_LIMIT = 200000;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   int mismatch_count, reports_pending, starts_seen, high_starts_seen, drops_seen;
   int ticks_sent;
   int cycle_count;
   bit gaps_on;

   two_class_priority_queue_server #(.RING_SLOTS(8)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   two_class_priority_queue_server_checker #(.RING_SLOTS(8)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .mismatch_count   (mismatch_count),
      .reports_pending  (reports_pending),
      .starts_seen      (starts_seen),
      .high_starts_seen (high_starts_seen),
      .drops_seen       (drops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      gaps_on    = 1'b1;
      ticks_sent = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding", cycle_count,
                  reports_pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial cycle_count = 0;

   function automatic logic [REQ_W-1:0] tick_word(input logic arrival, input logic to_high,
                                                  input logic [SLEN_W-1:0] slen);
      return {2'b00, slen, to_high, arrival};
   endfunction

   // one tick transfer, with a random hold-off in front of it while gaps are on
   task automatic send_tick(input logic [REQ_W-1:0] word);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ticks_sent++;
   endtask

   // receiver: holds off rsp_tready for a random time before each report while gaps are on
   initial begin : result_sink
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = gaps_on ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int phase_len, load_pct, high_pct, settle;
      logic [SLEN_W-1:0] slen;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // idle tick with the other bits set, then a long normal job blocks the server
      send_tick(tick_word(1'b0, 1'b1, 4'd15));
      send_tick(tick_word(1'b1, 1'b0, 4'd15));
      // overfill the high ring, then the normal ring, so both drop arrivals
      repeat (9) send_tick(tick_word(1'b1, 1'b1, 4'd15));
      repeat (9) send_tick(tick_word(1'b1, 1'b0, 4'd0));
      send_tick(tick_word(1'b0, 1'b0, 4'd0));
      send_tick(tick_word(1'b1, 1'b1, 4'd0));

      // random phases of light, medium or heavy load let the rings drain and fill
      while (ticks_sent < TICK_TARGET) begin
         phase_len = $urandom_range(20, 80);
         case ($urandom_range(0, 2))
            0: load_pct = 15;
            1: load_pct = 55;
            default: load_pct = 95;
         endcase
         high_pct = $urandom_range(0, 100);
         gaps_on  = ($urandom_range(0, 3) != 0);
         repeat (phase_len) begin
            slen = ($urandom_range(0, 19) == 0) ? 4'd0 : SLEN_W'($urandom_range(1, 15));
            send_tick(tick_word($urandom_range(0, 99) < load_pct,
                                $urandom_range(0, 99) < high_pct, slen));
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      gaps_on = 1'b1;

      while (reports_pending != 0) @(posedge clock);
      // allow for any stray report still in the pipeline
      settle = 0;
      while (settle < 10) begin
         @(posedge clock);
         settle++;
      end

      $display("sent %0d ticks; %0d services started (%0d high class), %0d arrivals dropped",
               ticks_sent, starts_seen, high_starts_seen, drops_seen);
      $display("%0d mismatches over %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
